/* src/hcbp_pkg.sv */
// Package for the code bit packer: field widths, item kinds, controller states
// and the command/status structs between controller and datapath.
// No dependencies.
package hcbp_pkg;

  // Default parameter values
  localparam int DEF_MAX_CODE_LEN = 32;
  localparam int DEF_SYMBOL_COUNT = 256;

  // Field and register widths
  localparam int KIND_W = 2;
  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 3;
  localparam int PEND_W = 7;
  localparam int ACC_W  = PEND_W + CODE_W;
  localparam int TOT_W  = 6;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD,
    ST_EMIT,
    ST_FLUSH,
    ST_PAD
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic tbl_write;
    logic tbl_read;
    logic acc_load;
    logic emit_code;
    logic commit;
    logic emit_flush;
    logic emit_pad;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sym_ok;
    logic total_ge8;
    logic pend_nonzero;
    logic slot_free;
  } sts_t;

endpackage

/* src/hcbp_if.sv */
// Valid/ready stream interfaces for the input items and the result bytes.
// Depends on hcbp_pkg for field widths.
interface hcbp_in_if import hcbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SYM_W-1:0]  symbol;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;

  modport source (output valid, kind, symbol, code_bits, code_length, input ready);
  modport sink   (input valid, kind, symbol, code_bits, code_length, output ready);
endinterface

interface hcbp_out_if import hcbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

/* src/hcbp_ctrl.sv */
// Controller state machine of the code bit packer.
// Depends on hcbp_pkg for states, item kinds and command/status structs.
module hcbp_ctrl import hcbp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_ready,
  input  sts_t              sts,
  output cmd_t              cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_ENCODE && sts.sym_ok) begin
            state_nxt = ST_BUILD;
          end else if (in_kind == KIND_END) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_BUILD: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // byte loop ends once fewer than eight bits remain
        if (!sts.total_ge8) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_nonzero || sts.slot_free) begin
          state_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        if (sts.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.tbl_write = in_valid && (in_kind == KIND_LOAD) && sts.sym_ok;
        cmd.tbl_read  = in_valid && (in_kind == KIND_ENCODE) && sts.sym_ok;
      end
      ST_BUILD: begin
        cmd.acc_load = 1'b1;
      end
      ST_EMIT: begin
        if (sts.total_ge8) begin
          cmd.emit_code = sts.slot_free;
        end else begin
          cmd.commit = 1'b1;
        end
      end
      ST_FLUSH: begin
        cmd.emit_flush = sts.pend_nonzero && sts.slot_free;
      end
      ST_PAD: begin
        cmd.emit_pad = sts.slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* src/hcbp_datapath.sv */
// Datapath of the code bit packer: code/length table, bit accumulator,
// pending bits and the output register. Depends on hcbp_pkg.
module hcbp_datapath import hcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [CODE_W-1:0] in_code_bits,
  input  logic [LEN_W-1:0]  in_code_length,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last
);

  localparam int IDX_W     = $clog2(SYMBOL_COUNT);
  localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  // Table storage; valid bits stand in for the zero reset of the lengths
  logic [CODE_W-1:0]       code_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]        len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] valid_r;

  logic [IDX_W-1:0]  idx;
  logic [LEN_W-1:0]  len_wr;
  logic [CODE_W-1:0] rd_code_r;
  logic [LEN_W-1:0]  rd_len_raw_r;
  logic              rd_hit_r;
  logic [LEN_W-1:0]  rd_len;

  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [PEND_W-1:0] pend_bits_r, pend_bits_nxt;
  logic [CNT_W-1:0]  pend_cnt_r, pend_cnt_nxt;

  logic [CODE_W-1:0] code_m;
  logic [ACC_W-1:0]  acc_build;
  logic [TOT_W-1:0]  total_build;
  logic [TOT_W-1:0]  shift_amt;
  logic [BYTE_W-1:0] code_byte;
  logic [CNT_W-1:0]  pad_cnt;
  logic [BYTE_W-1:0] flush_byte;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic              slot_free;

  // Symbol decode and length saturation
  assign idx    = in_symbol[IDX_W-1:0];
  assign len_wr = (in_code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : in_code_length;

  // Table write and registered read
  always_ff @(posedge clk) begin
    if (cmd.tbl_write) begin
      code_mem[idx] <= in_code_bits;
      len_mem[idx]  <= len_wr;
    end
    if (cmd.tbl_read) begin
      rd_code_r    <= code_mem[idx];
      rd_len_raw_r <= len_mem[idx];
      rd_hit_r     <= valid_r[idx];
    end
  end

  // Entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.tbl_write) begin
      valid_r[idx] <= 1'b1;
    end
  end

  assign rd_len = rd_hit_r ? rd_len_raw_r : '0;

  // Append code to pending bits
  always_comb begin
    code_m      = rd_code_r & ~({CODE_W{1'b1}} << rd_len);
    acc_build   = ({{CODE_W{1'b0}}, pend_bits_r} << rd_len) | {{PEND_W{1'b0}}, code_m};
    total_build = TOT_W'(pend_cnt_r) + rd_len;
  end

  // Byte extraction, first bit in the MSB
  assign shift_amt = total_r - TOT_W'(BYTE_W);
  assign code_byte = BYTE_W'(acc_r >> shift_amt);

  // Flush byte and padding count
  assign pad_cnt    = CNT_W'(0) - pend_cnt_r;
  assign flush_byte = {1'b0, pend_bits_r} << pad_cnt;

  // Accumulator and pending state next values
  always_comb begin
    acc_nxt       = acc_r;
    total_nxt     = total_r;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    if (cmd.acc_load) begin
      acc_nxt   = acc_build;
      total_nxt = total_build;
    end else if (cmd.emit_code) begin
      total_nxt = shift_amt;
    end
    if (cmd.commit) begin
      pend_bits_nxt = acc_r[PEND_W-1:0] & ~({PEND_W{1'b1}} << total_r[CNT_W-1:0]);
      pend_cnt_nxt  = total_r[CNT_W-1:0];
    end else if (cmd.emit_pad) begin
      pend_bits_nxt = '0;
      pend_cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    total_r <= total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

  // Output register
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (cmd.emit_code) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = code_byte;
      out_last_nxt  = (total_r < TOT_W'(2 * BYTE_W));
    end else if (cmd.emit_flush) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = flush_byte;
      out_last_nxt  = 1'b0;
    end else if (cmd.emit_pad) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = BYTE_W'(pad_cnt);
      out_last_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  // Status
  assign sts.sym_ok       = ({1'b0, in_symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
  assign sts.total_ge8    = (total_r >= TOT_W'(BYTE_W));
  assign sts.pend_nonzero = (pend_cnt_r != '0);
  assign sts.slot_free    = slot_free;

endmodule

/* src/huffman_code_bit_packer.sv */
// Code bit packer top level: controller plus datapath. Depends on hcbp_pkg, hcbp_if.
// Load item: table write. Encode item: table read, accumulator build, then n output
// bytes (0 to 4), one byte per cycle from the accumulator unless the output stalls,
// then commit. End item: flush byte if bits are pending, then padding byte. One item at a time.
// Reset (synchronous, active low) clears the controller, pending bits, output
// valid and all table valid bits at once; code storage is not cleared.
module huffman_code_bit_packer import hcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  hcbp_in_if.sink     in_ch,
  hcbp_out_if.source  out_ch
);

  cmd_t cmd;
  sts_t sts;

  // Controller
  hcbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  hcbp_datapath #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_symbol      (in_ch.symbol),
    .in_code_bits   (in_ch.code_bits),
    .in_code_length (in_ch.code_length),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_byte       (out_ch.out_byte),
    .out_last       (out_ch.last)
  );

`ifndef SYNTH
  // End transfer always keeps the input blocked for the flush
  a_end_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.kind == KIND_END) |=> !in_ch.ready)
    else $error("input ready after end transfer");

  // Encode of a valid symbol builds the accumulator next cycle
  a_build_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.kind == KIND_ENCODE && sts.sym_ok)
    |=> cmd.acc_load)
    else $error("accumulator build missing after encode");

  // No byte is produced while idle
  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !(cmd.emit_code || cmd.emit_flush || cmd.emit_pad))
    else $error("byte emitted while idle");

  // A byte is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_code || cmd.emit_flush || cmd.emit_pad) |-> sts.slot_free)
    else $error("output register overwritten");
`endif

endmodule
